// ===== design/fpa_pkg.sv =====
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;
    localparam int KIND_BITS     = 4;
    localparam int DATA_BITS     = 32;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADD      = 4'd0,
        KIND_SUB      = 4'd1,
        KIND_MUL      = 4'd2,
        KIND_DIV      = 4'd3,
        KIND_INC      = 4'd4,
        KIND_DEC      = 4'd5,
        KIND_LT       = 4'd6,
        KIND_GT       = 4'd7,
        KIND_LE       = 4'd8,
        KIND_GE       = 4'd9,
        KIND_EQ       = 4'd10,
        KIND_NE       = 4'd11,
        KIND_MIN      = 4'd12,
        KIND_MAX      = 4'd13,
        KIND_TO_INT   = 4'd14,
        KIND_FROM_INT = 4'd15
    } t_kind;

endpackage

// ===== design/fpa_if.sv =====
interface fpa_in_if;
    logic                             valid;
    logic                             ready;
    logic [fpa_pkg::KIND_BITS-1:0]    kind;
    logic signed [fpa_pkg::DATA_BITS-1:0] operand_a;
    logic signed [fpa_pkg::DATA_BITS-1:0] operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input kind, input operand_a, input operand_b,
                    output ready);
endinterface

interface fpa_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [fpa_pkg::DATA_BITS-1:0] value;
    logic                             compare_true;
    logic                             overflow;
    logic                             divide_by_zero;

    modport source (output valid, output value, output compare_true, output overflow,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input value, input compare_true, input overflow,
                    input divide_by_zero, output ready);
endinterface

// ===== design/fixed_point_q24_8_alu_core.sv =====
// Signed Q24.8 fixed-point ALU (add, sub, mul, div, inc, dec, compares, min/max,
// int conversions) with saturation, overflow and divide-by-zero flags. It takes
// one transaction per cycle while the output is not stalled and returns results
// in order: every transaction goes through the restoring divider, which resolves
// one quotient bit per stage, and the other operations are delayed to match.
// Multiply and divide round to nearest with halves away from zero. A stall at the
// output freezes the whole pipeline.
module fixed_point_q24_8_alu_core #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);
    import fpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int DL = WORD_BITS + FRAC_BITS + 1;
    localparam int ML = 3;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [W-1:0]         val;
        logic                 ov;
        logic                 cmp;
        logic                 dz;
    } t_side;

    typedef struct packed {
        logic [W-1:0] val;
        logic         ov;
    } t_res;

    logic en;
    logic [DL:0] r_vld;
    t_side r_side [0:DL-1];
    t_res  r_mdl  [0:DL-ML-1];
    t_side f_side;
    logic [W-1:0] f_ma, f_mb, mul_val, div_val;
    logic f_neg, mul_ov, div_ov;

    logic               r_out_valid;
    logic [W-1:0]       r_out_val;
    logic               r_out_cmp, r_out_ov, r_out_dz;
    t_side              last;
    t_res               n_res;

    assign en        = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    fpa_front #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_kind (i_in.kind),
        .i_a    (i_in.operand_a),
        .i_b    (i_in.operand_b),
        .o_kind (f_side.kind),
        .o_val  (f_side.val),
        .o_ov   (f_side.ov),
        .o_cmp  (f_side.cmp),
        .o_dz   (f_side.dz),
        .o_ma   (f_ma),
        .o_mb   (f_mb),
        .o_neg  (f_neg)
    );

    fpa_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ma  (f_ma),
        .i_mb  (f_mb),
        .i_neg (f_neg),
        .o_val (mul_val),
        .o_ov  (mul_ov)
    );

    fpa_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ma  (f_ma),
        .i_mb  (f_mb),
        .i_neg (f_neg),
        .o_val (div_val),
        .o_ov  (div_ov)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[DL-1:0], i_in.valid};
            r_out_valid <= r_vld[DL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= f_side;
            for (int i = 1; i < DL; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_mdl[0] <= '{val: mul_val, ov: mul_ov};
            for (int i = 1; i < DL - ML; i++) begin
                r_mdl[i] <= r_mdl[i-1];
            end
        end
    end

    assign last = r_side[DL-1];

    // pick the unit that produced this transaction
    always_comb begin
        n_res = '{val: last.val, ov: last.ov};
        if (t_kind'(last.kind) == KIND_MUL) begin
            n_res = r_mdl[DL-ML-1];
        end else if (t_kind'(last.kind) == KIND_DIV && !last.dz) begin
            n_res = '{val: div_val, ov: div_ov};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= n_res.val;
            r_out_ov  <= n_res.ov;
            r_out_cmp <= last.cmp;
            r_out_dz  <= last.dz;
        end
    end

    generate
        if (W >= DATA_BITS) begin : g_out_wide
            assign o_out.value = r_out_val[DATA_BITS-1:0];
        end else begin : g_out_narrow
            assign o_out.value = {{(DATA_BITS-W){r_out_val[W-1]}}, r_out_val};
        end
    endgenerate

    assign o_out.valid          = r_out_valid;
    assign o_out.compare_true   = r_out_cmp;
    assign o_out.overflow       = r_out_ov;
    assign o_out.divide_by_zero = r_out_dz;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_ov && r_out_dz) && !(r_out_cmp && r_out_ov))
        else $error("conflicting result flags");

    a_cmp_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmp) |-> r_out_val == '0)
        else $error("comparison result carries nonzero value");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && en) |=> r_vld[0])
        else $error("accepted transaction not captured");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld) && r_out_valid)
        else $error("pipeline moved during stall");

endmodule

// ===== design/fpa_front.sv =====
module fpa_front #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [fpa_pkg::KIND_BITS-1:0] i_kind,
    input  logic [fpa_pkg::DATA_BITS-1:0] i_a,
    input  logic [fpa_pkg::DATA_BITS-1:0] i_b,
    output logic [fpa_pkg::KIND_BITS-1:0] o_kind,
    output logic [WORD_BITS-1:0]          o_val,
    output logic                          o_ov,
    output logic                          o_cmp,
    output logic                          o_dz,
    output logic [WORD_BITS-1:0]          o_ma,
    output logic [WORD_BITS-1:0]          o_mb,
    output logic                          o_neg
);
    import fpa_pkg::*;

    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]   a_w, b_w;
    logic [W:0]     sum, dif;
    logic [W+F-1:0] shl;
    logic [W-1:0]   shl_lo;
    logic           shl_ov, lt, eq;

    generate
        if (W <= DATA_BITS) begin : g_narrow
            assign a_w = i_a[W-1:0];
            assign b_w = i_b[W-1:0];
        end else begin : g_wide
            assign a_w = {{(W-DATA_BITS){1'b0}}, i_a};
            assign b_w = {{(W-DATA_BITS){1'b0}}, i_b};
        end
    endgenerate

    assign sum    = {a_w[W-1], a_w} + {b_w[W-1], b_w};
    assign dif    = {a_w[W-1], a_w} - {b_w[W-1], b_w};
    assign shl    = $signed({{F{a_w[W-1]}}, a_w}) <<< F;
    assign shl_lo = shl[W-1:0];
    assign shl_ov = shl != {{F{shl_lo[W-1]}}, shl_lo};
    assign lt     = $signed(a_w) < $signed(b_w);
    assign eq     = a_w == b_w;

    logic [W-1:0] n_val;
    logic         n_ov, n_cmp, n_dz;

    always_comb begin
        n_val = '0;
        n_ov  = 1'b0;
        n_cmp = 1'b0;
        n_dz  = 1'b0;
        unique case (t_kind'(i_kind))
            KIND_ADD: begin
                n_ov  = sum[W] ^ sum[W-1];
                n_val = n_ov ? (sum[W] ? MINV : MAXV) : sum[W-1:0];
            end
            KIND_SUB: begin
                n_ov  = dif[W] ^ dif[W-1];
                n_val = n_ov ? (dif[W] ? MINV : MAXV) : dif[W-1:0];
            end
            KIND_DIV: begin
                n_dz  = b_w == '0;
                n_val = a_w[W-1] ? MINV : MAXV;
            end
            KIND_INC: begin
                n_ov  = a_w == MAXV;
                n_val = n_ov ? a_w : a_w + W'(1);
            end
            KIND_DEC: begin
                n_ov  = a_w == MINV;
                n_val = n_ov ? a_w : a_w - W'(1);
            end
            KIND_LT:  n_cmp = lt;
            KIND_GT:  n_cmp = !lt && !eq;
            KIND_LE:  n_cmp = lt || eq;
            KIND_GE:  n_cmp = !lt;
            KIND_EQ:  n_cmp = eq;
            KIND_NE:  n_cmp = !eq;
            KIND_MIN: n_val = lt ? a_w : b_w;
            KIND_MAX: n_val = lt ? b_w : a_w;
            KIND_TO_INT: n_val = $signed(a_w) >>> F;
            KIND_FROM_INT: begin
                n_ov  = shl_ov;
                n_val = shl_ov ? (a_w[W-1] ? MINV : MAXV) : shl_lo;
            end
            default: n_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_kind <= i_kind;
            o_val  <= n_val;
            o_ov   <= n_ov;
            o_cmp  <= n_cmp;
            o_dz   <= n_dz;
            o_ma   <= a_w[W-1] ? (~a_w + W'(1)) : a_w;
            o_mb   <= b_w[W-1] ? (~b_w + W'(1)) : b_w;
            o_neg  <= a_w[W-1] ^ b_w[W-1];
        end
    end

endmodule

// ===== design/fpa_mul.sv =====
module fpa_mul #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [WORD_BITS-1:0] i_ma,
    input  logic [WORD_BITS-1:0] i_mb,
    input  logic                 i_neg,
    output logic [WORD_BITS-1:0] o_val,
    output logic                 o_ov
);
    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int H  = (W + 1) / 2;
    localparam int G  = W - H;
    localparam int PW = 2 * W;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic [2*H-1:0] r_p00;
    logic [W-1:0]   r_p01, r_p10;
    logic [2*G-1:0] r_p11;
    logic           r_neg_a, r_neg_b;
    logic [PW-1:0]  r_prod;

    logic [PW-1:0] n_prod, t, q, lim;
    logic          ov;

    assign n_prod = PW'(r_p00) + (PW'(r_p01) << H) + (PW'(r_p10) << H)
                  + (PW'(r_p11) << (2*H));
    assign t      = r_prod + (PW'(1) << (F-1));
    assign q      = t >> F;
    assign lim    = PW'(MAXV) + PW'(r_neg_b);
    assign ov     = q > lim;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00   <= i_ma[H-1:0] * i_mb[H-1:0];
            r_p01   <= i_ma[H-1:0] * i_mb[W-1:H];
            r_p10   <= i_ma[W-1:H] * i_mb[H-1:0];
            r_p11   <= i_ma[W-1:H] * i_mb[W-1:H];
            r_neg_a <= i_neg;
            r_prod  <= n_prod;
            r_neg_b <= r_neg_a;
            o_ov    <= ov;
            o_val   <= ov ? (r_neg_b ? MINV : MAXV)
                          : (r_neg_b ? (~q[W-1:0] + W'(1)) : q[W-1:0]);
        end
    end

endmodule

// ===== design/fpa_div.sv =====
module fpa_div #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [WORD_BITS-1:0] i_ma,
    input  logic [WORD_BITS-1:0] i_mb,
    input  logic                 i_neg,
    output logic [WORD_BITS-1:0] o_val,
    output logic                 o_ov
);
    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int Q = W + F;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] r_rem [1:Q];
    logic [Q-1:0] r_num [1:Q];
    logic [W-1:0] r_den [1:Q];
    logic         r_neg [1:Q];

    genvar k;
    generate
        for (k = 0; k < Q; k++) begin : g_step
            logic [W-1:0] s_rem, s_den;
            logic [Q-1:0] s_num;
            logic         s_neg;
            logic [W:0]   sh;
            logic [W+1:0] diff;
            logic         qb;

            if (k == 0) begin : g_first
                assign s_rem = '0;
                assign s_num = {i_ma, {F{1'b0}}};
                assign s_den = i_mb;
                assign s_neg = i_neg;
            end else begin : g_next
                assign s_rem = r_rem[k];
                assign s_num = r_num[k];
                assign s_den = r_den[k];
                assign s_neg = r_neg[k];
            end

            assign sh   = {s_rem, s_num[Q-1]};
            assign diff = {1'b0, sh} - {2'b00, s_den};
            assign qb   = !diff[W+1];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= qb ? diff[W-1:0] : sh[W-1:0];
                    r_num[k+1] <= {s_num[Q-2:0], qb};
                    r_den[k+1] <= s_den;
                    r_neg[k+1] <= s_neg;
                end
            end
        end
    endgenerate

    logic         rnd, ov;
    logic [Q:0]   q1, lim;

    assign rnd = {r_rem[Q], 1'b0} >= {1'b0, r_den[Q]};
    assign q1  = {1'b0, r_num[Q]} + (Q+1)'(rnd);
    assign lim = (Q+1)'(MAXV) + (Q+1)'(r_neg[Q]);
    assign ov  = q1 > lim;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ov  <= ov;
            o_val <= ov ? (r_neg[Q] ? MINV : MAXV)
                        : (r_neg[Q] ? (~q1[W-1:0] + W'(1)) : q1[W-1:0]);
        end
    end

endmodule

// ===== verif/tb_fixed_point_q24_8_alu_core.sv =====
module tb_fixed_point_q24_8_alu_core;
    import fpa_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic               compare_true;
        logic               overflow;
        logic               divide_by_zero;
    } t_alu_result;

    class alu_scoreboard;
        t_alu_result pending_q[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void note_operation(t_kind kind, logic signed [31:0] a, logic signed [31:0] b);
            pending_q.push_back(compute_result(kind, a, b));
        endfunction

        function void check_result(t_alu_result got);
            t_alu_result want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                errors++;
            end
            if (got.compare_true !== want.compare_true) begin
                $display("%0t: compare_true expected %b actual %b", $time,
                         want.compare_true, got.compare_true);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %b actual %b", $time,
                         want.overflow, got.overflow);
                errors++;
            end
            if (got.divide_by_zero !== want.divide_by_zero) begin
                $display("%0t: divide_by_zero expected %b actual %b", $time,
                         want.divide_by_zero, got.divide_by_zero);
                errors++;
            end
        endfunction
    endclass

    localparam logic signed [31:0] MAX_Q = 32'sh7fffffff;
    localparam logic signed [31:0] MIN_Q = 32'sh80000000;

    function automatic logic signed [31:0] saturate(logic signed [127:0] x, ref logic ov);
        if (x > 128'sd2147483647) begin
            ov = 1'b1;
            return MAX_Q;
        end
        if (x < -128'sd2147483648) begin
            ov = 1'b1;
            return MIN_Q;
        end
        return x[31:0];
    endfunction

    function automatic t_alu_result compute_result(t_kind kind, logic signed [31:0] a,
                                                   logic signed [31:0] b);
        t_alu_result r;
        logic signed [127:0] wa, wb, x;
        logic [127:0] ma, mb, q, rem;
        logic ov;
        r = '0;
        ov = 1'b0;
        wa = a;
        wb = b;
        ma = a[31] ? -wa : wa;
        mb = b[31] ? -wb : wb;
        case (kind)
            KIND_ADD: r.value = saturate(wa + wb, ov);
            KIND_SUB: r.value = saturate(wa - wb, ov);
            KIND_MUL: begin
                q = (ma * mb + 128'd128) >> 8;
                x = (a[31] != b[31]) ? -$signed(q) : $signed(q);
                r.value = saturate(x, ov);
            end
            KIND_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                    r.value = a[31] ? MIN_Q : MAX_Q;
                end else begin
                    q = (ma << 8) / mb;
                    rem = (ma << 8) % mb;
                    if (rem >= mb - rem) q = q + 1;
                    x = (a[31] != b[31]) ? -$signed(q) : $signed(q);
                    r.value = saturate(x, ov);
                end
            end
            KIND_INC: r.value = saturate(wa + 1, ov);
            KIND_DEC: r.value = saturate(wa - 1, ov);
            KIND_LT: r.compare_true = a < b;
            KIND_GT: r.compare_true = a > b;
            KIND_LE: r.compare_true = a <= b;
            KIND_GE: r.compare_true = a >= b;
            KIND_EQ: r.compare_true = a == b;
            KIND_NE: r.compare_true = a != b;
            KIND_MIN: r.value = (a < b) ? a : b;
            KIND_MAX: r.value = (a > b) ? a : b;
            KIND_TO_INT: r.value = a >>> 8;
            default: r.value = saturate(wa <<< 8, ov);
        endcase
        r.overflow = ov;
        return r;
    endfunction

    logic i_clk;
    logic i_rst_n;
    fpa_in_if  in_bus();
    fpa_out_if out_bus();

    fixed_point_q24_8_alu_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    alu_scoreboard scoreboard = new();
    int  idle_cycles;
    bit  timed_out;
    bit  sending_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.kind = '0;
        in_bus.operand_a = '0;
        in_bus.operand_b = '0;
        out_bus.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready)
            scoreboard.check_result({out_bus.value, out_bus.compare_true,
                                     out_bus.overflow, out_bus.divide_by_zero});
        if (i_rst_n && in_bus.valid && in_bus.ready)
            scoreboard.note_operation(t_kind'(in_bus.kind), in_bus.operand_a,
                                      in_bus.operand_b);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
            timed_out <= 1'b1;
    end

    initial begin
        int gap;
        out_bus.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk iff out_bus.valid);
        end
    end

    task automatic send_operation(t_kind kind, logic signed [31:0] a, logic signed [31:0] b,
                                  int gap);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.kind <= kind;
        in_bus.operand_a <= a;
        in_bus.operand_b <= b;
        @(posedge i_clk iff in_bus.ready);
    endtask

    function automatic logic signed [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return MAX_Q - $urandom_range(0, 2);
            1: return MIN_Q + $urandom_range(0, 2);
            2: return $signed($urandom_range(0, 1023)) - 512;
            3: return $signed($urandom) >>> $urandom_range(0, 24);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int gap;
        sending_done = 1'b0;
        timed_out = 1'b0;
        @(posedge i_clk iff i_rst_n);
        send_operation(KIND_ADD, MAX_Q, 32'sd1, 0);
        send_operation(KIND_ADD, MIN_Q, -32'sd1, 0);
        send_operation(KIND_SUB, MIN_Q, 32'sd1, 0);
        send_operation(KIND_SUB, MAX_Q, -32'sd1, 0);
        send_operation(KIND_MUL, 32'sd384, -32'sd128, 0);
        send_operation(KIND_MUL, 32'sd1, 32'sd128, 0);
        send_operation(KIND_MUL, -32'sd1, 32'sd128, 0);
        send_operation(KIND_MUL, MAX_Q, MAX_Q, 0);
        send_operation(KIND_MUL, MIN_Q, MIN_Q, 0);
        send_operation(KIND_DIV, 32'sd256, 32'sd0, 0);
        send_operation(KIND_DIV, -32'sd256, 32'sd0, 0);
        send_operation(KIND_DIV, 32'sd0, 32'sd0, 0);
        send_operation(KIND_DIV, MIN_Q, 32'sd1, 0);
        send_operation(KIND_DIV, 32'sd1, 32'sd512, 0);
        send_operation(KIND_INC, MAX_Q, 32'sd5, 0);
        send_operation(KIND_DEC, MIN_Q, -32'sd5, 0);
        send_operation(KIND_LT, MIN_Q, MAX_Q, 0);
        send_operation(KIND_GT, MIN_Q, MAX_Q, 0);
        send_operation(KIND_LE, 32'sd7, 32'sd7, 0);
        send_operation(KIND_GE, 32'sd7, 32'sd7, 0);
        send_operation(KIND_EQ, 32'sd7, 32'sd7, 0);
        send_operation(KIND_NE, MIN_Q, MAX_Q, 0);
        send_operation(KIND_MIN, -32'sd3, -32'sd3, 0);
        send_operation(KIND_MAX, MIN_Q, MAX_Q, 0);
        send_operation(KIND_TO_INT, -32'sd1, MAX_Q, 0);
        send_operation(KIND_FROM_INT, 32'sh00800000, 32'sd0, 0);
        send_operation(KIND_FROM_INT, -32'sh00800001, 32'sd0, 0);
        in_bus.valid <= 1'b0;
        // drain the pipeline before going random
        wait (scoreboard.pending_q.size() == 0 || timed_out);
        for (int n = 0; n < 1250; n++) begin
            gap = (n % 200 < 60) ? 0 : $urandom_range(0, 10);
            send_operation(t_kind'($urandom_range(0, 15)), random_operand(),
                           ($urandom_range(0, 15) == 0) ? 32'sd0 : random_operand(), gap);
        end
        in_bus.valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        wait ((sending_done && scoreboard.pending_q.size() == 0) || timed_out);
        if (timed_out) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            repeat (60) @(posedge i_clk);
            if (scoreboard.errors == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
            $finish;
        end
    end
endmodule
